// ===== rtl/lpps_pkg.sv =====
package lpps_pkg;

    localparam int PIXELS_PER_LINE = 32;
    localparam int PIXEL_BITS      = 8;

    localparam int THR_W  = 8;
    localparam int BASE_W = 8;
    localparam int PG_W   = 16;
    localparam int DG_W   = 12;
    localparam int REC_W  = 9;
    localparam int DMAX_W = 8;
    localparam int MS_W   = 16;
    localparam int ERR_W  = 16;
    localparam int DRV_W  = 9;
    localparam int ST_W   = 2;

    localparam int IDX_W      = $clog2(PIXELS_PER_LINE + 1);
    localparam int HALF       = PIXELS_PER_LINE / 2;
    localparam int MAX_WEIGHT = PIXELS_PER_LINE - HALF;
    localparam int WS_W       = $clog2(MAX_WEIGHT * PIXELS_PER_LINE + 1) + 1;
    localparam int CMP_W      = (PIXEL_BITS > THR_W) ? PIXEL_BITS : THR_W;

    localparam int ERR_FRAC = 10;
    localparam int ERR_QW   = $clog2(MAX_WEIGHT * (2 ** ERR_FRAC) + 1);
    localparam int DRV_QW   = 11;
    localparam int Q_W      = (ERR_QW > DRV_QW) ? ERR_QW : DRV_QW;
    localparam int CNT_W    = $clog2(Q_W);
    localparam int EQ_W     = ((ERR_QW > ERR_W) ? ERR_QW : ERR_W) + 1;
    localparam logic signed [EQ_W-1:0] ERR_HI = EQ_W'(2 ** (ERR_W - 1) - 1);
    localparam logic signed [EQ_W-1:0] ERR_LO = -EQ_W'(2 ** (ERR_W - 1));

    localparam int DEN_SH = 18;
    localparam int D_SH   = 8;
    localparam int DIFF_W = ERR_W + 1;
    localparam int T1_W   = ERR_W + PG_W + 1;
    localparam int T2_W   = DIFF_W + DG_W + 1;
    localparam int BM_W   = BASE_W + MS_W;
    localparam int N_W    = T1_W + MS_W + 1;
    localparam int REM_W  = N_W - 1;

    localparam int NUM_REGS  = 7;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(NUM_REGS * 4);
    localparam int REG_IDX_W = ADDR_W - 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_WHITE_THRESHOLD,
        REG_BASE_SPEED,
        REG_P_GAIN,
        REG_D_GAIN,
        REG_RECOVER_FAST,
        REG_RECOVER_SLOW,
        REG_DRIVE_MAX
    } t_reg_idx;

    localparam logic [ST_W-1:0] LS_TRACK = 2'd0;
    localparam logic [ST_W-1:0] LS_LOST  = 2'd1;
    localparam logic [ST_W-1:0] LS_WHITE = 2'd2;

    localparam logic [THR_W-1:0]         RST_WHITE_THRESHOLD = 8'd125;
    localparam logic [BASE_W-1:0]        RST_BASE_SPEED      = 8'd90;
    localparam logic [PG_W-1:0]          RST_P_GAIN          = 16'd448;
    localparam logic [DG_W-1:0]          RST_D_GAIN          = 12'd340;
    localparam logic signed [REC_W-1:0]  RST_RECOVER_FAST    = 9'sd40;
    localparam logic signed [REC_W-1:0]  RST_RECOVER_SLOW    = -9'sd15;
    localparam logic [DMAX_W-1:0]        RST_DRIVE_MAX       = 8'd255;

    typedef struct packed {
        logic [THR_W-1:0]        white_threshold;
        logic [BASE_W-1:0]       base_speed;
        logic [PG_W-1:0]         p_gain;
        logic [DG_W-1:0]         d_gain;
        logic signed [REC_W-1:0] recover_fast;
        logic signed [REC_W-1:0] recover_slow;
        logic [DMAX_W-1:0]       drive_max;
    } t_cfg;

    typedef struct packed {
        logic pix_acc;
        logic ld_err_div;
        logic div_step;
        logic err_ld;
        logic mul1;
        logic mul2;
        logic num;
        logic nlr;
        logic ld_drv_div;
        logic fin_lost;
        logic fin_white;
        logic fin_track;
        logic out_ld;
    } t_cmd;

    typedef struct packed {
        logic lost;
        logic all_white;
    } t_sts;

endpackage

// ===== rtl/lpps_if.sv =====
interface lpps_pix_if;
    import lpps_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_value;
    logic                  last_in_line;
    logic [MS_W-1:0]       elapsed_ms;

    modport source (output valid, output pixel_value, output last_in_line,
                    output elapsed_ms, input ready);
    modport sink   (input valid, input pixel_value, input last_in_line,
                    input elapsed_ms, output ready);
endinterface

interface lpps_drv_if;
    import lpps_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [DRV_W-1:0] left_drive;
    logic signed [DRV_W-1:0] right_drive;
    logic [ST_W-1:0]         line_state;

    modport source (output valid, output left_drive, output right_drive,
                    output line_state, input ready);
    modport sink   (input valid, input left_drive, input right_drive,
                    input line_state, output ready);
endinterface

// ===== rtl/lpps_regs.sv =====
module lpps_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpps_pkg::ADDR_W-1:0]   paddr,
    input  logic [lpps_pkg::DATA_W-1:0]   pwdata,
    output logic [lpps_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output lpps_pkg::t_cfg                o_cfg
);
    import lpps_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.white_threshold <= RST_WHITE_THRESHOLD;
            r_cfg.base_speed      <= RST_BASE_SPEED;
            r_cfg.p_gain          <= RST_P_GAIN;
            r_cfg.d_gain          <= RST_D_GAIN;
            r_cfg.recover_fast    <= RST_RECOVER_FAST;
            r_cfg.recover_slow    <= RST_RECOVER_SLOW;
            r_cfg.drive_max       <= RST_DRIVE_MAX;
        end else if (w_wr) begin
            case (w_idx)
                REG_WHITE_THRESHOLD: r_cfg.white_threshold <= pwdata[THR_W-1:0];
                REG_BASE_SPEED:      r_cfg.base_speed      <= pwdata[BASE_W-1:0];
                REG_P_GAIN:          r_cfg.p_gain          <= pwdata[PG_W-1:0];
                REG_D_GAIN:          r_cfg.d_gain          <= pwdata[DG_W-1:0];
                REG_RECOVER_FAST:    r_cfg.recover_fast    <= $signed(pwdata[REC_W-1:0]);
                REG_RECOVER_SLOW:    r_cfg.recover_slow    <= $signed(pwdata[REC_W-1:0]);
                REG_DRIVE_MAX:       r_cfg.drive_max       <= pwdata[DMAX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_WHITE_THRESHOLD: prdata = DATA_W'(r_cfg.white_threshold);
            REG_BASE_SPEED:      prdata = DATA_W'(r_cfg.base_speed);
            REG_P_GAIN:          prdata = DATA_W'(r_cfg.p_gain);
            REG_D_GAIN:          prdata = DATA_W'(r_cfg.d_gain);
            REG_RECOVER_FAST:    prdata = DATA_W'($unsigned(r_cfg.recover_fast));
            REG_RECOVER_SLOW:    prdata = DATA_W'($unsigned(r_cfg.recover_slow));
            REG_DRIVE_MAX:       prdata = DATA_W'(r_cfg.drive_max);
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== rtl/lpps_ctrl.sv =====
module lpps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  lpps_pkg::t_sts   i_sts,
    output lpps_pkg::t_cmd   o_cmd
);
    import lpps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_EDIV,
        S_ERR,
        S_MUL1,
        S_MUL2,
        S_NUM,
        S_NLR,
        S_DLD,
        S_DDIV,
        S_FIN,
        S_OUT
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.pix_acc = 1'b1;
                    if (i_in_last) n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                if (i_sts.lost) begin
                    o_cmd.fin_lost = 1'b1;
                    n_state        = S_OUT;
                end else if (i_sts.all_white) begin
                    o_cmd.fin_white = 1'b1;
                    n_state         = S_OUT;
                end else begin
                    o_cmd.ld_err_div = 1'b1;
                    n_cnt            = CNT_W'(ERR_QW - 1);
                    n_state          = S_EDIV;
                end
            end
            S_EDIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) n_state = S_ERR;
                else             n_cnt   = r_cnt - 1'b1;
            end
            S_ERR: begin
                o_cmd.err_ld = 1'b1;
                n_state      = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_NUM;
            end
            S_NUM: begin
                o_cmd.num = 1'b1;
                n_state   = S_NLR;
            end
            S_NLR: begin
                o_cmd.nlr = 1'b1;
                n_state   = S_DLD;
            end
            S_DLD: begin
                o_cmd.ld_drv_div = 1'b1;
                n_cnt            = CNT_W'(DRV_QW - 1);
                n_state          = S_DDIV;
            end
            S_DDIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) n_state = S_FIN;
                else             n_cnt   = r_cnt - 1'b1;
            end
            S_FIN: begin
                o_cmd.fin_track = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_ld = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/lpps_dp.sv =====
module lpps_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lpps_pkg::t_cfg                       i_cfg,
    input  lpps_pkg::t_cmd                       i_cmd,
    output lpps_pkg::t_sts                       o_sts,
    input  logic [lpps_pkg::PIXEL_BITS-1:0]      i_pixel_value,
    input  logic [lpps_pkg::MS_W-1:0]            i_elapsed_ms,
    output logic signed [lpps_pkg::DRV_W-1:0]    o_left_drive,
    output logic signed [lpps_pkg::DRV_W-1:0]    o_right_drive,
    output logic [lpps_pkg::ST_W-1:0]            o_line_state
);
    import lpps_pkg::*;

    function automatic logic signed [DRV_W-1:0] clamp_drive(
        input logic signed [DRV_W-1:0] v,
        input logic [DMAX_W-1:0]       dm
    );
        logic signed [DRV_W:0] v_x;
        logic signed [DRV_W:0] m_x;
        v_x = {v[DRV_W-1], v};
        m_x = $signed((DRV_W + 1)'(dm));
        if (v_x > m_x)       return DRV_W'(m_x);
        else if (v_x < -m_x) return DRV_W'(-m_x);
        else                 return v;
    endfunction

    function automatic logic signed [DRV_W-1:0] drive_of(
        input logic [DRV_QW-1:0] q,
        input logic              neg,
        input logic [DMAX_W-1:0] dm
    );
        logic [DMAX_W-1:0] mag;
        mag = (q > DRV_QW'(dm)) ? dm : DMAX_W'(q);
        return neg ? -$signed(DRV_W'(mag)) : $signed(DRV_W'(mag));
    endfunction

    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         r_wc;
    logic signed [WS_W-1:0]   r_ws;
    logic [MS_W-1:0]          r_ms;
    logic signed [ERR_W-1:0]  r_prev;
    logic signed [DRV_W-1:0]  r_held_l, r_held_r;
    logic [ST_W-1:0]          r_st;

    logic [REM_W-1:0]         r_rem_l, r_rem_r, r_dv;
    logic [Q_W-1:0]           r_q_l, r_q_r;
    logic                     r_neg_l, r_neg_r;

    logic signed [ERR_W-1:0]  r_err;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [T1_W-1:0]   r_t1;
    logic signed [T2_W-1:0]   r_t2;
    logic [BM_W-1:0]          r_bm;
    logic signed [N_W-1:0]    r_t3, r_num, r_nl, r_nr;

    logic signed [DRV_W-1:0]  r_o_left, r_o_right;
    logic [ST_W-1:0]          r_o_st;

    logic signed [WS_W-1:0]   w_idx_s, w_weight;
    logic                     w_white;
    logic [WS_W-1:0]          w_ws_mag;
    logic [EQ_W-1:0]          w_qe;
    logic signed [EQ_W-1:0]   w_ev;
    logic signed [ERR_W-1:0]  n_err;
    logic signed [N_W-1:0]    w_sp;
    logic [N_W-1:0]           w_nl_mag, w_nr_mag;
    logic signed [DRV_W-1:0]  n_lost_l, n_lost_r;

    assign o_sts.lost      = (r_wc == '0);
    assign o_sts.all_white = (r_wc == r_idx);

    assign o_left_drive  = r_o_left;
    assign o_right_drive = r_o_right;
    assign o_line_state  = r_o_st;

    always_comb begin
        w_idx_s  = $signed(WS_W'(r_idx));
        if (r_idx < IDX_W'(HALF)) w_weight = w_idx_s - $signed(WS_W'(HALF));
        else                      w_weight = w_idx_s - $signed(WS_W'(HALF)) + $signed(WS_W'(1));
        w_white  = CMP_W'(i_pixel_value) > CMP_W'(i_cfg.white_threshold);

        w_ws_mag = r_ws[WS_W-1] ? WS_W'(-r_ws) : WS_W'(r_ws);

        w_qe = EQ_W'(r_q_l[ERR_QW-1:0]);
        w_ev = r_neg_l ? -$signed(w_qe) : $signed(w_qe);
        if (w_ev > ERR_HI)      n_err = ERR_W'(ERR_HI);
        else if (w_ev < ERR_LO) n_err = ERR_W'(ERR_LO);
        else                    n_err = ERR_W'(w_ev);

        w_sp     = $signed(N_W'(r_bm)) <<< DEN_SH;
        w_nl_mag = r_nl[N_W-1] ? N_W'(-r_nl) : N_W'(r_nl);
        w_nr_mag = r_nr[N_W-1] ? N_W'(-r_nr) : N_W'(r_nr);

        if (r_prev > 0) begin
            n_lost_l = i_cfg.recover_slow;
            n_lost_r = i_cfg.recover_fast;
        end else if (r_prev < 0) begin
            n_lost_l = i_cfg.recover_fast;
            n_lost_r = i_cfg.recover_slow;
        end else begin
            n_lost_l = r_held_l;
            n_lost_r = r_held_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_wc     <= '0;
            r_ws     <= '0;
            r_prev   <= '0;
            r_held_l <= '0;
            r_held_r <= '0;
        end else begin
            if (i_cmd.pix_acc && (r_idx < IDX_W'(PIXELS_PER_LINE))) begin
                r_idx <= r_idx + 1'b1;
                if (w_white) begin
                    r_wc <= r_wc + 1'b1;
                    r_ws <= r_ws + w_weight;
                end
            end
            if (i_cmd.fin_lost || i_cmd.fin_white || i_cmd.fin_track) begin
                r_idx <= '0;
                r_wc  <= '0;
                r_ws  <= '0;
            end
            if (i_cmd.fin_lost) begin
                r_prev   <= '0;
                r_held_l <= clamp_drive(n_lost_l, i_cfg.drive_max);
                r_held_r <= clamp_drive(n_lost_r, i_cfg.drive_max);
            end
            if (i_cmd.fin_white) begin
                r_prev   <= '0;
                r_held_l <= clamp_drive(r_held_l, i_cfg.drive_max);
                r_held_r <= clamp_drive(r_held_r, i_cfg.drive_max);
            end
            if (i_cmd.fin_track) begin
                r_prev   <= r_err;
                r_held_l <= drive_of(r_q_l[DRV_QW-1:0], r_neg_l, i_cfg.drive_max);
                r_held_r <= drive_of(r_q_r[DRV_QW-1:0], r_neg_r, i_cfg.drive_max);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_acc) r_ms <= (i_elapsed_ms == '0) ? MS_W'(1) : i_elapsed_ms;
        if (i_cmd.fin_lost)  r_st <= LS_LOST;
        if (i_cmd.fin_white) r_st <= LS_WHITE;
        if (i_cmd.fin_track) r_st <= LS_TRACK;

        if (i_cmd.ld_err_div) begin
            r_rem_l <= REM_W'(w_ws_mag) << ERR_FRAC;
            r_rem_r <= '0;
            r_dv    <= REM_W'(r_wc) << (ERR_QW - 1);
            r_q_l   <= '0;
            r_q_r   <= '0;
            r_neg_l <= r_ws[WS_W-1];
            r_neg_r <= 1'b0;
        end else if (i_cmd.ld_drv_div) begin
            r_rem_l <= w_nl_mag[REM_W-1:0];
            r_rem_r <= w_nr_mag[REM_W-1:0];
            r_dv    <= REM_W'(r_ms) << (DEN_SH + DRV_QW - 1);
            r_q_l   <= '0;
            r_q_r   <= '0;
            r_neg_l <= r_nl[N_W-1];
            r_neg_r <= r_nr[N_W-1];
        end else if (i_cmd.div_step) begin
            if (r_rem_l >= r_dv) begin
                r_rem_l <= r_rem_l - r_dv;
                r_q_l   <= {r_q_l[Q_W-2:0], 1'b1};
            end else begin
                r_q_l   <= {r_q_l[Q_W-2:0], 1'b0};
            end
            if (r_rem_r >= r_dv) begin
                r_rem_r <= r_rem_r - r_dv;
                r_q_r   <= {r_q_r[Q_W-2:0], 1'b1};
            end else begin
                r_q_r   <= {r_q_r[Q_W-2:0], 1'b0};
            end
            r_dv <= r_dv >> 1;
        end

        if (i_cmd.err_ld) begin
            r_err  <= n_err;
            r_diff <= $signed(DIFF_W'(n_err)) - $signed(DIFF_W'(r_prev));
        end
        if (i_cmd.mul1) begin
            r_t1 <= $signed(T1_W'(r_err)) * $signed({1'b0, i_cfg.p_gain});
            r_t2 <= $signed(T2_W'(r_diff)) * $signed({1'b0, i_cfg.d_gain});
            r_bm <= BM_W'(i_cfg.base_speed) * BM_W'(r_ms);
        end
        if (i_cmd.mul2) r_t3  <= $signed(N_W'(r_t1)) * $signed({1'b0, r_ms});
        if (i_cmd.num)  r_num <= r_t3 + ($signed(N_W'(r_t2)) <<< D_SH);
        if (i_cmd.nlr) begin
            r_nl <= w_sp - r_num;
            r_nr <= w_sp + r_num;
        end

        if (i_cmd.out_ld) begin
            r_o_left  <= r_held_l;
            r_o_right <= r_held_r;
            r_o_st    <= r_st;
        end
    end

endmodule

// ===== rtl/line_position_pd_steering.sv =====
// PD steering from one scan line. Pixels are taken one per cycle while a line
// is being collected; each of the first 32 is compared with white_threshold,
// and those above it are counted and weighted by their position. The pixel
// flagged last_in_line closes the line and produces one request of left and
// right drive plus line state. A lost or all-white line goes from S_CLASS to
// S_OUT; a tracked line also runs the shared restoring divider: 15 steps for
// the position error (weighted sum over white count, Q6.10) and 11 steps that
// divide both drive numerators by the elapsed time at once. No pixel is taken
// until S_OUT loads the request; a finished request waits in the output
// register while the next line is collected. Configuration registers sit at
// byte address 4*i of the APB port: white_threshold, base_speed, p_gain,
// d_gain, recover_fast, recover_slow, drive_max.
module line_position_pd_steering (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lpps_pix_if.sink                      i_pix,
    lpps_drv_if.source                    o_drv,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpps_pkg::ADDR_W-1:0]   paddr,
    input  logic [lpps_pkg::DATA_W-1:0]   pwdata,
    output logic [lpps_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import lpps_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    lpps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lpps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_in_last   (i_pix.last_in_line),
        .o_in_ready  (i_pix.ready),
        .i_out_ready (o_drv.ready),
        .o_out_valid (o_drv.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lpps_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_pixel_value (i_pix.pixel_value),
        .i_elapsed_ms  (i_pix.elapsed_ms),
        .o_left_drive  (o_drv.left_drive),
        .o_right_drive (o_drv.right_drive),
        .o_line_state  (o_drv.line_state)
    );

endmodule

// ===== rtl/lpps_checker.sv =====
module lpps_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [lpps_pkg::DRV_W-1:0]   i_left_drive,
    input logic signed [lpps_pkg::DRV_W-1:0]   i_right_drive,
    input logic [lpps_pkg::ST_W-1:0]           i_line_state
);
    import lpps_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_left_drive) && $stable(i_right_drive) && $stable(i_line_state))
        else $error("request changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("request pending after reset");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("request appeared right after a pixel");

endmodule

bind line_position_pd_steering lpps_checker u_lpps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pix.valid),
    .i_in_ready    (i_pix.ready),
    .i_out_valid   (o_drv.valid),
    .i_out_ready   (o_drv.ready),
    .i_left_drive  (o_drv.left_drive),
    .i_right_drive (o_drv.right_drive),
    .i_line_state  (o_drv.line_state)
);

// ===== verif/line_position_pd_steering_tb.sv =====
`timescale 1ns / 100ps

module line_position_pd_steering_tb;
    import lpps_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic signed [DRV_W-1:0] left_drive;
        logic signed [DRV_W-1:0] right_drive;
        logic [ST_W-1:0]         line_state;
    } t_drive_cmd;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    lpps_pix_if pix_if ();
    lpps_drv_if drv_if ();

    line_position_pd_steering u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_drv   (drv_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_drive_cmd expected_drives[$];
    int         err_cnt     = 0;
    int         pixels_sent = 0;
    int         cycles      = 0;
    int         stall_left  = 0;
    bit         idle_on     = 1'b1;

    int thr_m, base_m, pg_m, dg_m, rfast_m, rslow_m, dmax_m;
    int line_idx, white_cnt, wsum, prev_err, hold_left, hold_right;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!idle_on) begin
            drv_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            drv_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            drv_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 8);
        end else begin
            drv_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_drive_cmd want;
        if (i_rst_n && drv_if.valid && drv_if.ready) begin
            if (expected_drives.size() == 0) begin
                $display("%0t unexpected request: left %0d right %0d state %0d", $time,
                         drv_if.left_drive, drv_if.right_drive, drv_if.line_state);
                err_cnt++;
            end else begin
                want = expected_drives.pop_front();
                if (want.left_drive !== drv_if.left_drive) begin
                    $display("%0t left_drive expected %0d actual %0d", $time,
                             want.left_drive, drv_if.left_drive);
                    err_cnt++;
                end
                if (want.right_drive !== drv_if.right_drive) begin
                    $display("%0t right_drive expected %0d actual %0d", $time,
                             want.right_drive, drv_if.right_drive);
                    err_cnt++;
                end
                if (want.line_state !== drv_if.line_state) begin
                    $display("%0t line_state expected %0d actual %0d", $time,
                             want.line_state, drv_if.line_state);
                    err_cnt++;
                end
            end
        end
    end

    function automatic int pixel_weight(int k);
        return (k < HALF) ? k - HALF : k - HALF + 1;
    endfunction

    function automatic int clamp_drive(longint v);
        if (v > longint'(dmax_m)) return dmax_m;
        if (v < -longint'(dmax_m)) return -dmax_m;
        return int'(v);
    endfunction

    task automatic steer_model_pixel(input logic [7:0] pix, input bit is_last,
                                     input logic [15:0] ms);
        longint     err, diff, num, den, sp;
        int         ms_eff, l, r;
        t_drive_cmd want;
        if (line_idx < PIXELS_PER_LINE) begin
            if (int'(pix) > thr_m) begin
                white_cnt++;
                wsum += pixel_weight(line_idx);
            end
            line_idx++;
        end
        if (is_last) begin
            ms_eff = (ms == 0) ? 1 : int'(ms);
            if (white_cnt == 0) begin
                want.line_state = LS_LOST;
                if (prev_err > 0) begin
                    l = rslow_m;
                    r = rfast_m;
                end else if (prev_err < 0) begin
                    l = rfast_m;
                    r = rslow_m;
                end else begin
                    l = hold_left;
                    r = hold_right;
                end
                prev_err = 0;
            end else if (white_cnt == line_idx) begin
                want.line_state = LS_WHITE;
                l = hold_left;
                r = hold_right;
                prev_err = 0;
            end else begin
                err = (longint'(wsum) * 1024) / longint'(white_cnt);
                if (err > 32767) err = 32767;
                if (err < -32768) err = -32768;
                diff = err - longint'(prev_err);
                den  = longint'(262144) * longint'(ms_eff);
                num  = err * longint'(pg_m) * longint'(ms_eff)
                     + diff * longint'(dg_m) * 256;
                sp   = longint'(base_m) * den;
                l = clamp_drive((sp - num) / den);
                r = clamp_drive((sp + num) / den);
                prev_err = int'(err);
                want.line_state = LS_TRACK;
            end
            l = clamp_drive(l);
            r = clamp_drive(r);
            hold_left  = l;
            hold_right = r;
            line_idx   = 0;
            white_cnt  = 0;
            wsum       = 0;
            want.left_drive  = DRV_W'(l);
            want.right_drive = DRV_W'(r);
            expected_drives.push_back(want);
        end
    endtask

    task automatic wait_drained();
        pix_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_drives.size() != 0);
    endtask

    task automatic write_reg(input t_reg_idx idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= (idx == REG_RECOVER_FAST || idx == REG_RECOVER_SLOW) ?
                   DATA_W'(value & 'h1ff) : DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_WHITE_THRESHOLD: thr_m   = value;
            REG_BASE_SPEED:      base_m  = value;
            REG_P_GAIN:          pg_m    = value;
            REG_D_GAIN:          dg_m    = value;
            REG_RECOVER_FAST:    rfast_m = value;
            REG_RECOVER_SLOW:    rslow_m = value;
            REG_DRIVE_MAX:       dmax_m  = value;
            default: ;
        endcase
    endtask

    task automatic program_regs(input int thr, input int base, input int pg, input int dg,
                                input int rf, input int rs, input int dmax);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_WHITE_THRESHOLD, thr);
        write_reg(REG_BASE_SPEED, base);
        write_reg(REG_P_GAIN, pg);
        write_reg(REG_D_GAIN, dg);
        write_reg(REG_RECOVER_FAST, rf);
        write_reg(REG_RECOVER_SLOW, rs);
        write_reg(REG_DRIVE_MAX, dmax);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] pix, input bit is_last,
                              input logic [15:0] ms, input bit gaps);
        if (gaps && $urandom_range(0, 5) == 0) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        pix_if.valid        <= 1'b1;
        pix_if.pixel_value  <= pix;
        pix_if.last_in_line <= is_last;
        pix_if.elapsed_ms   <= ms;
        do @(posedge i_clk); while (!pix_if.ready);
        steer_model_pixel(pix, is_last, ms);
        pixels_sent++;
    endtask

    function automatic logic [15:0] pick_elapsed();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hffff;
        if (r < 5) return 16'($urandom);
        return 16'($urandom_range(1, 50));
    endfunction

    task automatic send_random_line();
        int         len, pattern, band_lo, band_hi, r;
        bit         white, gaps, is_last;
        logic [7:0] pix;
        r = $urandom_range(0, 99);
        if (r < 70) len = PIXELS_PER_LINE;
        else if (r < 85) len = $urandom_range(1, PIXELS_PER_LINE - 1);
        else len = $urandom_range(PIXELS_PER_LINE + 1, PIXELS_PER_LINE + 8);
        pattern = $urandom_range(0, 9);
        band_lo = $urandom_range(0, PIXELS_PER_LINE - 1);
        band_hi = band_lo + $urandom_range(1, 10);
        gaps    = idle_on && ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 19) == 0) wait_drained();
        for (int i = 0; i < len; i++) begin
            case (pattern)
                0:       white = 1'b0;
                1:       white = 1'b1;
                2, 3:    white = $urandom_range(0, 1);
                default: white = (i >= band_lo) && (i < band_hi);
            endcase
            if ($urandom_range(0, 15) == 0) pix = 8'($urandom);
            else if (white) pix = (thr_m >= 255) ? 8'hff : 8'($urandom_range(thr_m + 1, 255));
            else pix = 8'($urandom_range(0, thr_m));
            is_last = (i == len - 1);
            send_pixel(pix, is_last, is_last ? pick_elapsed() : 16'($urandom), gaps);
        end
    endtask

    task automatic run_lines(input int budget);
        int stop;
        stop = pixels_sent + budget;
        while (pixels_sent < stop) send_random_line();
    endtask

    task automatic test_directed_cases();
        send_pixel(8'd255, 1'b0, 16'($urandom), 1'b1);
        send_pixel(8'd125, 1'b1, 16'd0, 1'b1);
        send_pixel(8'd0, 1'b0, 16'($urandom), 1'b1);
        send_pixel(8'd0, 1'b1, 16'hffff, 1'b1);
        send_pixel(8'd0, 1'b1, 16'd7, 1'b1);
        send_pixel(8'd126, 1'b1, 16'd3, 1'b1);
        for (int i = 0; i < HALF; i++)
            send_pixel(8'($urandom_range(0, 125)), 1'b0, 16'($urandom), 1'b1);
        send_pixel(8'd200, 1'b1, 16'd1, 1'b1);
        send_pixel(8'd0, 1'b1, 16'd20, 1'b1);
    endtask

    task automatic test_default_lines();
        run_lines(150);
    endtask

    task automatic test_register_extremes();
        program_regs(0, 255, 65535, 4095, 255, -255, 255);
        run_lines(100);
        program_regs(255, 0, 0, 0, -255, 255, 0);
        run_lines(100);
        program_regs(128, 128, 1, 1, -1, 1, 100);
        run_lines(100);
    endtask

    task automatic test_random_registers();
        int dmax;
        repeat (5) begin
            dmax = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(64, 255);
            program_regs($urandom_range(60, 200), $urandom_range(0, 255),
                         $urandom_range(0, 65535), $urandom_range(0, 4095),
                         int'($urandom_range(0, 510)) - 255,
                         int'($urandom_range(0, 510)) - 255, dmax);
            run_lines(140);
        end
    endtask

    task automatic test_back_to_back();
        program_regs(125, 90, 448, 340, 40, -15, 255);
        idle_on = 1'b0;
        run_lines(150);
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        pix_if.valid        <= 1'b0;
        pix_if.pixel_value  <= '0;
        pix_if.last_in_line <= 1'b0;
        pix_if.elapsed_ms   <= '0;
        thr_m      = int'(RST_WHITE_THRESHOLD);
        base_m     = int'(RST_BASE_SPEED);
        pg_m       = int'(RST_P_GAIN);
        dg_m       = int'(RST_D_GAIN);
        rfast_m    = int'(RST_RECOVER_FAST);
        rslow_m    = int'(RST_RECOVER_SLOW);
        dmax_m     = int'(RST_DRIVE_MAX);
        line_idx   = 0;
        white_cnt  = 0;
        wsum       = 0;
        prev_err   = 0;
        hold_left  = 0;
        hold_right = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_default_lines();
        test_register_extremes();
        test_random_registers();
        test_back_to_back();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lpps_pkg.sv
rtl/lpps_if.sv
rtl/lpps_regs.sv
rtl/lpps_ctrl.sv
rtl/lpps_dp.sv
rtl/line_position_pd_steering.sv
rtl/lpps_checker.sv
verif/line_position_pd_steering_tb.sv
